@@ hw/rtl/button_click_classifier_macros.svh @@
// shared assertion macros for the button click classifier
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bcc_pkg.sv @@
package bcc_pkg;

  localparam int CntW = 16;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // configuration register indexes
  localparam logic [1:0] REG_INVERT_INPUT       = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS_TICKS   = 2'd1;
  localparam logic [1:0] REG_DOUBLE_CLICK_TICKS = 2'd2;

  // reset values
  localparam logic            RstInvert    = 1'b0;
  localparam logic [CntW-1:0] RstLongTicks = 16'd100;
  localparam logic [CntW-1:0] RstDblTicks  = 16'd25;

  typedef struct packed {
    logic            invert_input;
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] double_click_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      status_code;
    logic            press_event;
    logic            release_event;
    logic            short_event;
    logic            long_start;
    logic            long_held;
    logic            double_click;
    logic [CntW-1:0] press_ticks;
  } res_t;

endpackage

@@ hw/rtl/bcc_if.sv @@
// input channel: one scan tick per item
interface bcc_in_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink (input valid, input raw_level, output ready);
endinterface

// result channel: one classification per item
interface bcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status_code;
  logic        press_event;
  logic        release_event;
  logic        short_event;
  logic        long_start;
  logic        long_held;
  logic        double_click;
  logic [15:0] press_ticks;

  modport source (
    output valid, output status_code, output press_event, output release_event,
    output short_event, output long_start, output long_held, output double_click,
    output press_ticks, input ready
  );
  modport sink (
    input valid, input status_code, input press_event, input release_event,
    input short_event, input long_start, input long_held, input double_click,
    input press_ticks, output ready
  );
endinterface

// configuration write channel
interface bcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bcc_cfg_regs.sv @@
module bcc_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [15:0]       wr_data,
  output bcc_pkg::cfg_t     cfg
);
  import bcc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_input       <= RstInvert;
      cfg.long_press_ticks   <= RstLongTicks;
      cfg.double_click_ticks <= RstDblTicks;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_INVERT_INPUT:       cfg.invert_input       <= wr_data[0];
        REG_LONG_PRESS_TICKS:   cfg.long_press_ticks   <= wr_data[CntW-1:0];
        REG_DOUBLE_CLICK_TICKS: cfg.double_click_ticks <= wr_data[CntW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

@@ hw/rtl/bcc_core.sv @@
module bcc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          raw_level,
  input  bcc_pkg::cfg_t cfg,
  output bcc_pkg::res_t res
);
  import bcc_pkg::*;
  `include "button_click_classifier_macros.svh"

  typedef enum logic [1:0] {
    ST_RELEASE = 2'd0,
    ST_PRESSED = 2'd1,
    ST_SHORT   = 2'd2,
    ST_LONG    = 2'd3
  } status_t;

  status_t         st, st1, st_next;
  logic [CntW-1:0] cnt, cnt_inc, cnt1, cnt_next;
  logic [CntW-1:0] win, win1, win_inc, win2, win_dec, win_next;
  logic            active, long_hit, pressed;
  logic            ev_press, ev_release, ev_short, ev_double;

  always_comb begin
    // held press: saturating count, long threshold check
    active   = (st == ST_PRESSED) || (st == ST_LONG);
    cnt_inc  = (cnt != CntMax) ? cnt + 16'd1 : cnt;
    cnt1     = active ? cnt_inc : cnt;
    long_hit = active && (cnt1 >= cfg.long_press_ticks);
    st1      = long_hit ? ST_LONG : st;
    win1     = long_hit ? '0 : win;

    // open window ages, closes when past the limit or on wrap
    win_inc = win1 + 16'd1;
    if (win1 == '0) begin
      win2 = '0;
    end else if ((win_inc != '0) && (win1 > cfg.double_click_ticks)) begin
      win2 = '0;
    end else begin
      win2 = win_inc;
    end
    win_dec = win2 - 16'd1;

    pressed = raw_level ^ cfg.invert_input;

    st_next    = st1;
    cnt_next   = cnt1;
    win_next   = win2;
    ev_press   = 1'b0;
    ev_release = 1'b0;
    ev_short   = 1'b0;
    ev_double  = 1'b0;

    if (pressed && (st1 != ST_SHORT)) begin
      if (st1 == ST_RELEASE) begin
        st_next  = ST_PRESSED;
        cnt_next = '0;
        ev_press = 1'b1;
      end
    end else begin
      priority if (st1 == ST_PRESSED) begin
        st_next  = ST_SHORT;
        ev_short = 1'b1;
        if (win2 == '0) begin
          win_next = 16'd1;
        end else if (win_dec <= cfg.double_click_ticks) begin
          ev_double = 1'b1;
          win_next  = '0;
        end
      end else if (st1 != ST_RELEASE) begin
        // short or long ends, also a press while short
        st_next    = ST_RELEASE;
        ev_release = 1'b1;
      end else begin
        // released and not pressed: nothing changes
      end
    end

    res.status_code   = st_next;
    res.press_event   = ev_press;
    res.release_event = ev_release;
    res.short_event   = ev_short;
    res.long_start    = long_hit && (cnt1 == cfg.long_press_ticks);
    res.long_held     = long_hit;
    res.double_click  = ev_double;
    res.press_ticks   = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_RELEASE;
      cnt <= '0;
      win <= '0;
    end else if (step) begin
      st  <= st_next;
      cnt <= cnt_next;
      win <= win_next;
    end
  end

  `BCC_ASSERT_NOW(a_lstart_held, step && res.long_start, res.long_held, "long start without long held")
  `BCC_ASSERT_NOW(a_dbl_short, step && res.double_click, res.short_event, "double click without short press")
  `BCC_ASSERT_NEXT(a_press_clears, step && ev_press, (st == ST_PRESSED) && (cnt == '0), "press did not start count")
  `BCC_ASSERT_NEXT(a_long_closes, step && long_hit, win == '0, "long press left click window open")

endmodule

@@ hw/rtl/button_click_classifier.sv @@
// channel   | dir | handshake      | payload
// ----------+-----+----------------+-----------------------------------------------
// samples   | in  | valid / ready  | raw_level
// results   | out | valid / ready  | status_code, six event flags, press_ticks
// cfg       | in  | valid / ready  | index (2 bits), data (16 bits)
//
// one item per cycle sustained while results.ready stays high
// path: input register -> classify logic in bcc_core -> result register
// samples.ready drops only when both the input and result registers are full and stalled
// cfg is always ready; registers are meant to change only while no item is in flight
// rst (synchronous, active high) clears status, press count, click window and config
module button_click_classifier (
  input logic       clk,
  input logic       rst,
  bcc_in_if.sink    samples,
  bcc_out_if.source results,
  bcc_cfg_if.sink   cfg
);
  import bcc_pkg::*;
  `include "button_click_classifier_macros.svh"

  cfg_t cfg_q;
  res_t res_comb;
  res_t res_q;

  // input register
  logic s1_valid;
  logic s1_raw;

  // result register
  logic out_valid;

  logic out_free;  // result register empty or being drained
  logic advance;   // item moves from input register into result register

  assign out_free      = !out_valid || results.ready;
  assign advance       = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;
  assign cfg.ready     = 1'b1;

  bcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  // classify logic and status/counter state, stepped once per item
  bcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .raw_level (s1_raw),
    .cfg       (cfg_q),
    .res       (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (samples.ready) begin
        s1_valid <= samples.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_raw <= samples.raw_level;
    end
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign results.valid         = out_valid;
  assign results.status_code   = res_q.status_code;
  assign results.press_event   = res_q.press_event;
  assign results.release_event = res_q.release_event;
  assign results.short_event   = res_q.short_event;
  assign results.long_start    = res_q.long_start;
  assign results.long_held     = res_q.long_held;
  assign results.double_click  = res_q.double_click;
  assign results.press_ticks   = res_q.press_ticks;

  `BCC_ASSERT_NEXT(a_stall_keeps, out_valid && !results.ready, out_valid, "stalled item dropped")
  `BCC_ASSERT_NEXT(a_item_moves, advance, out_valid, "advanced item not in result register")
  `BCC_ASSERT_NOW(a_ready_free, s1_valid && !samples.ready, out_valid && !results.ready, "input stalled without output stall")

endmodule

@@ verif/button_click_classifier_tb.sv @@
module button_click_classifier_tb;
  import bcc_pkg::*;

  // status codes as the result channel reports them
  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_LONG     = 2'd3
  } btn_state_e;

  // index with no register behind it, writes to it must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // generous bound for about 1100 ticks in all,
  // even with both sides idling
  localparam int unsigned CycleLimit = 200_000;

  logic clk;
  logic rst;

  bcc_in_if  samples_if ();
  bcc_out_if results_if ();
  bcc_cfg_if cfg_if ();

  button_click_classifier u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // clock, 4 time units per period
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // classifier model: own copy of status, counters and configuration
  // ---------------------------------------------------------------------------
  cfg_t        cfg_model;
  btn_state_e  btn_state;
  logic [15:0] hold_cnt;
  logic [15:0] window_cnt;

  // results still owed by the block, oldest first
  res_t expected_clicks[$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned error_count;
  int unsigned result_count;
  int unsigned cycle_count;

  // one scan tick through the classifier, returns the result it must produce
  function automatic res_t classify_tick(input logic lvl);
    res_t r;
    logic held;
    r = '0;
    // press duration advances while the button is down, saturating
    if (btn_state == ST_PRESSED || btn_state == ST_LONG) begin
      if (hold_cnt != CntMax) hold_cnt = hold_cnt + 16'd1;
      if (hold_cnt >= cfg_model.long_press_ticks) begin
        window_cnt  = '0;
        btn_state   = ST_LONG;
        r.long_start = (hold_cnt == cfg_model.long_press_ticks);
        r.long_held  = 1'b1;
      end
    end
    // double-click window ages, closes past the limit or wraps to closed after the top value
    if (window_cnt != 0) begin
      window_cnt = window_cnt + 16'd1;
      if (window_cnt != 0 && (window_cnt - 16'd1) > cfg_model.double_click_ticks)
        window_cnt = '0;
    end
    held = lvl ^ cfg_model.invert_input;
    if (held && btn_state != ST_SHORT) begin
      // a new press only starts from released
      if (btn_state == ST_RELEASED) begin
        btn_state     = ST_PRESSED;
        hold_cnt      = '0;
        r.press_event = 1'b1;
      end
    end else if (btn_state == ST_PRESSED) begin
      btn_state     = ST_SHORT;
      r.short_event = 1'b1;
      if (window_cnt == 0) begin
        window_cnt = 16'd1;
      end else if ((window_cnt - 16'd1) <= cfg_model.double_click_ticks) begin
        r.double_click = 1'b1;
        window_cnt     = '0;
      end
    end else if (btn_state != ST_RELEASED) begin
      // also the forced release when a press comes during short
      btn_state       = ST_RELEASED;
      r.release_event = 1'b1;
    end
    r.status_code = btn_state;
    r.press_ticks = hold_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one scan tick, with random sender gaps ahead of it
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid     <= 1'b1;
    samples_if.raw_level <= lvl;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    expected_clicks.push_back(classify_tick(lvl));
    @(negedge clk);
  endtask

  // n ticks with the button logically down or up, inversion applied
  task automatic hold_level(input logic pressed, input int n);
    repeat (n) send_tick(pressed ^ cfg_model.invert_input);
  endtask

  // raw levels, oldest in the top bit
  task automatic send_pattern(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  // register write, model follows on acceptance
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_INVERT_INPUT:       cfg_model.invert_input       = value[0];
      REG_LONG_PRESS_TICKS:   cfg_model.long_press_ticks   = value;
      REG_DOUBLE_CLICK_TICKS: cfg_model.double_click_ticks = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // all three registers; the invert write carries random upper bits
  task automatic apply_cfg(input logic inv, input logic [15:0] long_t,
                           input logic [15:0] dbl_t);
    cfg_write(REG_INVERT_INPUT, {15'($urandom), inv});
    cfg_write(REG_LONG_PRESS_TICKS, long_t);
    cfg_write(REG_DOUBLE_CLICK_TICKS, dbl_t);
  endtask

  // stop sending and let every owed result come out, block then idle
  task automatic drain_clicks();
    samples_if.valid <= 1'b0;
    while (expected_clicks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // mostly well-formed press/release runs sized around the current thresholds,
  // the rest random level noise
  task automatic click_burst(input int n);
    int sent;
    int plen;
    int gap;
    int lt;
    int dcap;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 7) begin
        lt   = cfg_model.long_press_ticks;
        dcap = (cfg_model.double_click_ticks > 37) ? 40 : cfg_model.double_click_ticks + 3;
        case ($urandom_range(2))
          0: plen = $urandom_range(1, 3);
          1: plen = (lt > 150) ? $urandom_range(1, 150)
                               : $urandom_range((lt > 1) ? lt - 1 : 1, lt + 2);
          default: plen = $urandom_range(1, 30);
        endcase
        gap = $urandom_range(1) ? $urandom_range(0, 6) : $urandom_range(0, dcap);
        hold_level(1'b1, plen);
        hold_level(1'b0, gap);
        sent += plen + gap;
      end else begin
        plen = $urandom_range(1, 8);
        repeat (plen) send_tick(1'($urandom_range(1)));
        sent += plen;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: long press at 100 ticks, window of 25, no inversion
  task automatic test_reset_defaults();
    set_idle(21, 21);
    click_burst(200);
    drain_clicks();
  endtask

  // double click, forced release from short, long start and held
  task automatic test_directed_patterns();
    set_idle(0, 0);
    apply_cfg(1'b0, 16'd3, 16'd4);
    send_pattern(32'b10010010101111100, 17);
    drain_clicks();
  endtask

  // low level counts as pressed; only bit 0 of the write matters
  task automatic test_inverted_input();
    cfg_write(REG_INVERT_INPUT, 16'hFFFF);
    send_pattern(32'b1001101, 7);
    drain_clicks();
    cfg_write(REG_INVERT_INPUT, 16'hFFFE);
    send_pattern(32'b10, 2);
    drain_clicks();
  endtask

  // zero threshold: long on the first held tick, long start never
  task automatic test_zero_long_threshold();
    cfg_write(REG_LONG_PRESS_TICKS, 16'd0);
    send_pattern(32'b11100100, 8);
    drain_clicks();
  endtask

  // write to the unused index leaves all registers alone
  task automatic test_unused_index();
    cfg_write(REG_LONG_PRESS_TICKS, 16'd2);
    cfg_write(REG_UNUSED, 16'hFFFF);
    send_pattern(32'b11110, 5);
    drain_clicks();
  endtask

  // random click traffic over several settings and idling mixes
  task automatic test_random_phases();
    logic        inv;
    logic [15:0] long_t;
    logic [15:0] dbl_t;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin inv = 1'b0; long_t = 16'd1;     dbl_t = 16'd0;     end
        1: begin inv = 1'b1; long_t = 16'd0;     dbl_t = 16'hFFFF;  end
        2: begin inv = 1'b0; long_t = 16'hFFFF;  dbl_t = 16'd65533; end
        default: begin
          inv    = 1'($urandom_range(1));
          long_t = 16'($urandom_range(2, 20));
          dbl_t  = 16'($urandom_range(0, 12));
        end
      endcase
      apply_cfg(inv, long_t, dbl_t);
      case (ph % 4)
        0: set_idle(0, 0);
        1: set_idle(59, 0);
        2: set_idle(0, 59);
        default: set_idle(21, 21);
      endcase
      click_burst(110);
      drain_clicks();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic note_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  // receiver stalls, changed on the falling edge
  always @(negedge clk) begin
    results_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // every accepted result against the oldest owed one
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      got.status_code   = results_if.status_code;
      got.press_event   = results_if.press_event;
      got.release_event = results_if.release_event;
      got.short_event   = results_if.short_event;
      got.long_start    = results_if.long_start;
      got.long_held     = results_if.long_held;
      got.double_click  = results_if.double_click;
      got.press_ticks   = results_if.press_ticks;
      if (expected_clicks.size() == 0) begin
        note_error($sformatf("result %0d: no result expected", result_count));
      end else begin
        want = expected_clicks.pop_front();
        if (got.status_code   !== want.status_code   ||
            got.press_event   !== want.press_event   ||
            got.release_event !== want.release_event ||
            got.short_event   !== want.short_event   ||
            got.long_start    !== want.long_start    ||
            got.long_held     !== want.long_held     ||
            got.double_click  !== want.double_click  ||
            got.press_ticks   !== want.press_ticks)
          // flags: press release short long_start long_held double
          note_error($sformatf(
            "result %0d: exp st=%0d flags=%b%b%b%b%b%b ticks=%0d, got st=%0d flags=%b%b%b%b%b%b ticks=%0d",
            result_count, want.status_code, want.press_event, want.release_event,
            want.short_event, want.long_start, want.long_held, want.double_click,
            want.press_ticks, got.status_code, got.press_event, got.release_event,
            got.short_event, got.long_start, got.long_held, got.double_click,
            got.press_ticks));
      end
      result_count++;
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("button_click_classifier: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    // all inputs known from time zero
    rst                  = 1'b1;
    samples_if.valid     = 1'b0;
    samples_if.raw_level = 1'b0;
    results_if.ready     = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_INVERT_INPUT;
    cfg_if.data          = '0;
    send_idle_pct        = 0;
    stall_pct            = 0;
    error_count          = 0;
    result_count         = 0;
    cycle_count          = 0;
    // model starts where reset leaves the block
    cfg_model  = '{invert_input: RstInvert, long_press_ticks: RstLongTicks,
                   double_click_ticks: RstDblTicks};
    btn_state  = ST_RELEASED;
    hold_cnt   = '0;
    window_cnt = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_patterns();
    test_inverted_input();
    test_zero_long_threshold();
    test_unused_index();
    test_random_phases();

    // everything in, now let the pipeline settle before judging
    drain_clicks();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("button_click_classifier: match");
    end else begin
      $display("button_click_classifier: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_if.sv
hw/rtl/bcc_cfg_regs.sv
hw/rtl/bcc_core.sv
hw/rtl/button_click_classifier.sv
verif/button_click_classifier_tb.sv
